// ===== rtl/core/lpg_pkg.sv =====
// Package: sizes, word types, configuration record and register indexes of the lookahead gate.
`timescale 1ns / 1ps
package lpg_pkg;

  localparam int DELAY_DEPTH = 65536;
  localparam int PROB_DEPTH  = 4096;
  localparam int SAMPLE_BITS = 24;

  localparam int DW    = $clog2(DELAY_DEPTH);
  localparam int PW    = $clog2(PROB_DEPTH);
  localparam int CLR_W = (DW > PW) ? DW : PW;

  localparam int GAIN_W = 17;
  localparam int COEF_W = 16;
  localparam int PROB_W = 16;
  localparam int OFF_W  = 17;
  localparam int CFG_W  = 17;
  localparam int IDX_W  = 3;

  localparam logic [GAIN_W-1:0] UNITY = GAIN_W'(65536);

  localparam logic [IDX_W-1:0] CFG_DELAY_LENGTH = 3'd0;
  localparam logic [IDX_W-1:0] CFG_PROB_OFFSET  = 3'd1;
  localparam logic [IDX_W-1:0] CFG_THRESHOLD    = 3'd2;
  localparam logic [IDX_W-1:0] CFG_FLOOR_GAIN   = 3'd3;
  localparam logic [IDX_W-1:0] CFG_ATTACK_COEF  = 3'd4;
  localparam logic [IDX_W-1:0] CFG_RELEASE_COEF = 3'd5;

  localparam logic CMD_PROB_WRITE = 1'b0;
  localparam logic CMD_SAMPLE     = 1'b1;

  typedef struct packed {
    logic                          command;
    logic [11:0]                   prob_index;
    logic [PROB_W-1:0]             prob_value;
    logic signed [SAMPLE_BITS-1:0] left_in;
    logic signed [SAMPLE_BITS-1:0] right_in;
    logic                          block_start;
  } in_word_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] left_out;
    logic signed [SAMPLE_BITS-1:0] right_out;
    logic [GAIN_W-1:0]             gain;
    logic [PROB_W-1:0]             probability;
    logic [SAMPLE_BITS-1:0]        in_peak;
    logic [SAMPLE_BITS-1:0]        out_peak;
  } out_word_t;

  typedef struct packed {
    logic [15:0]             delay_length;
    logic signed [OFF_W-1:0] prob_offset;
    logic [PROB_W-1:0]       threshold;
    logic [GAIN_W-1:0]       floor_gain;
    logic [COEF_W-1:0]       attack_coef;
    logic [COEF_W-1:0]       release_coef;
  } cfg_t;

  typedef struct packed {
    logic env_pick;
    logic env_update;
    logic scale;
  } gain_ctrl_t;

endpackage

// ===== rtl/core/lookahead_probability_gate.sv =====
// Top level of the stereo lookahead gate: control sequencer, delay and probability memories.
//
//   channel | signals                          | moves
//   --------+----------------------------------+------------------------------
//   in      | in_valid in_ready in_data        | probability write or sample
//   out     | out_valid out_ready out_data     | gated sample, gain, peaks
//   cfg     | cfg_we cfg_index cfg_data        | one register per write
//
// A probability write goes to memory as it is accepted; a sample steps through the
// memory read, the two envelope multiply steps, the gain multiply and the output step.
// After reset a clearing pass over max(DELAY_DEPTH, PROB_DEPTH) addresses zeroes
// both memories; no word is accepted then, configuration writes are.
// A waiting result word holds in the output register; a finished sample
// stalls in its last step until that register is free.
`timescale 1ns / 1ps
module lookahead_probability_gate (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  lpg_pkg::in_word_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output lpg_pkg::out_word_t out_data,
  input  logic               cfg_we,
  input  logic [lpg_pkg::IDX_W-1:0] cfg_index,
  input  logic [lpg_pkg::CFG_W-1:0] cfg_data
);
  import lpg_pkg::*;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_ENV1  = 3'd2;
  localparam logic [2:0] S_ENV2  = 3'd3;
  localparam logic [2:0] S_SCALE = 3'd4;
  localparam logic [2:0] S_OUT   = 3'd5;

  localparam logic [CLR_W-1:0] CLR_LAST = {CLR_W{1'b1}};

  logic [2:0]             state_r, state_nxt;
  logic [CLR_W-1:0]       clr_cnt_r;
  logic [DW-1:0]          wpos_r;
  logic [PW-1:0]          cnt_r;
  logic [SAMPLE_BITS-1:0] in_peak_r, out_peak_r;
  logic                   out_valid_r;
  out_word_t              out_data_r;
  cfg_t                   cfg_r;

  logic signed [SAMPLE_BITS-1:0] lin_r, rin_r;
  logic                          bs_r;

  logic accept, accept_prob, accept_smp, load_out;

  logic                     d_we, d_re, p_we, p_re;
  logic [DW-1:0]            d_waddr, d_raddr;
  logic [PW-1:0]            p_waddr, p_raddr;
  logic [2*SAMPLE_BITS-1:0] d_wdata, d_rdata;
  logic [PROB_W-1:0]        p_wdata, p_rdata;

  gain_ctrl_t                    gctrl;
  logic [GAIN_W-1:0]             env;
  logic signed [SAMPLE_BITS-1:0] dl, dr, ol, orr;
  logic [SAMPLE_BITS-1:0]        mag_dl, mag_ol, in_base, out_base;
  logic [SAMPLE_BITS-1:0]        in_peak_nxt, out_peak_nxt;

  assign in_ready    = (state_r == S_IDLE);
  assign accept      = in_valid && in_ready;
  assign accept_prob = accept && (in_data.command == CMD_PROB_WRITE);
  assign accept_smp  = accept && (in_data.command == CMD_SAMPLE);
  assign load_out    = (state_r == S_OUT) && (!out_valid_r || out_ready);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: if (clr_cnt_r == CLR_LAST) state_nxt = S_IDLE;
      S_IDLE:  if (accept_smp) state_nxt = S_ENV1;
      S_ENV1:  state_nxt = S_ENV2;
      S_ENV2:  state_nxt = S_SCALE;
      S_SCALE: state_nxt = S_OUT;
      S_OUT:   if (load_out) state_nxt = S_IDLE;
      default: state_nxt = S_CLEAR;
    endcase
  end

  always_comb begin
    d_we    = 1'b0;
    d_waddr = wpos_r;
    d_wdata = {lin_r, rin_r};
    p_we    = 1'b0;
    p_waddr = PW'(in_data.prob_index);
    p_wdata = in_data.prob_value;
    if (state_r == S_CLEAR) begin
      d_we    = 1'b1;
      d_waddr = clr_cnt_r[DW-1:0];
      d_wdata = '0;
      p_we    = 1'b1;
      p_waddr = clr_cnt_r[PW-1:0];
      p_wdata = '0;
    end else begin
      d_we = (state_r == S_ENV1);
      p_we = accept_prob;
    end
  end

  assign d_re    = accept_smp;
  assign d_raddr = wpos_r - DW'(cfg_r.delay_length);
  assign p_re    = accept_smp;
  assign p_raddr = cnt_r + PW'(unsigned'(cfg_r.prob_offset));

  lpg_ram #(.WIDTH(2 * SAMPLE_BITS), .DEPTH(DELAY_DEPTH)) u_delay_ram (
    .clk   (clk),
    .we    (d_we),
    .waddr (d_waddr),
    .wdata (d_wdata),
    .re    (d_re),
    .raddr (d_raddr),
    .rdata (d_rdata)
  );

  lpg_ram #(.WIDTH(PROB_W), .DEPTH(PROB_DEPTH)) u_prob_ram (
    .clk   (clk),
    .we    (p_we),
    .waddr (p_waddr),
    .wdata (p_wdata),
    .re    (p_re),
    .raddr (p_raddr),
    .rdata (p_rdata)
  );

  assign dl = d_rdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
  assign dr = d_rdata[SAMPLE_BITS-1:0];

  assign gctrl.env_pick   = (state_r == S_ENV1);
  assign gctrl.env_update = (state_r == S_ENV2);
  assign gctrl.scale      = (state_r == S_SCALE);

  lpg_gain u_gain (
    .clk   (clk),
    .rst_n (rst_n),
    .ctrl  (gctrl),
    .cfg   (cfg_r),
    .prob  (p_rdata),
    .dl    (dl),
    .dr    (dr),
    .env   (env),
    .ol    (ol),
    .orr   (orr)
  );

  always_comb begin
    mag_dl       = dl[SAMPLE_BITS-1] ? SAMPLE_BITS'(-dl) : SAMPLE_BITS'(dl);
    mag_ol       = ol[SAMPLE_BITS-1] ? SAMPLE_BITS'(-ol) : SAMPLE_BITS'(ol);
    in_base      = bs_r ? '0 : in_peak_r;
    out_base     = bs_r ? '0 : out_peak_r;
    in_peak_nxt  = (mag_dl > in_base) ? mag_dl : in_base;
    out_peak_nxt = (mag_ol > out_base) ? mag_ol : out_base;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_cnt_r   <= '0;
      wpos_r      <= '0;
      cnt_r       <= '0;
      in_peak_r   <= '0;
      out_peak_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_CLEAR) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
      end
      if (state_r == S_ENV1) begin
        wpos_r <= wpos_r + 1'b1;
        cnt_r  <= cnt_r + 1'b1;
      end
      if (load_out) begin
        in_peak_r   <= in_peak_nxt;
        out_peak_r  <= out_peak_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept_smp) begin
      lin_r <= in_data.left_in;
      rin_r <= in_data.right_in;
      bs_r  <= in_data.block_start;
    end
    if (load_out) begin
      out_data_r.left_out    <= ol;
      out_data_r.right_out   <= orr;
      out_data_r.gain        <= env;
      out_data_r.probability <= p_rdata;
      out_data_r.in_peak     <= in_peak_nxt;
      out_data_r.out_peak    <= out_peak_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.delay_length <= 16'd36000;
      cfg_r.prob_offset  <= -OFF_W'(10112);
      cfg_r.threshold    <= PROB_W'(32768);
      cfg_r.floor_gain   <= '0;
      cfg_r.attack_coef  <= COEF_W'(65264);
      cfg_r.release_coef <= COEF_W'(65509);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_DELAY_LENGTH: cfg_r.delay_length <= cfg_data[15:0];
        CFG_PROB_OFFSET:  cfg_r.prob_offset  <= signed'(cfg_data[OFF_W-1:0]);
        CFG_THRESHOLD:    cfg_r.threshold    <= cfg_data[PROB_W-1:0];
        CFG_FLOOR_GAIN:   cfg_r.floor_gain   <= (cfg_data[GAIN_W-1:0] > UNITY) ?
                                                UNITY : cfg_data[GAIN_W-1:0];
        CFG_ATTACK_COEF:  cfg_r.attack_coef  <= cfg_data[COEF_W-1:0];
        CFG_RELEASE_COEF: cfg_r.release_coef <= cfg_data[COEF_W-1:0];
        default: ;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_no_accept_after_reset: assert property (@(posedge clk)
    $past(!rst_n) |-> !in_ready)
    else $error("word accepted during memory clear");

  a_out_from_last_step: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(state_r == S_OUT))
    else $error("result word raised outside the output step");

  a_gain_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.gain <= UNITY))
    else $error("gain above unity");

  a_peak_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.out_peak <= out_data.in_peak))
    else $error("gated peak exceeds input peak");

endmodule

// ===== rtl/core/lpg_ram.sv =====
// Generic simple dual-port RAM with one write port and one registered read port.
`timescale 1ns / 1ps
module lpg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/core/lpg_gain.sv =====
// Envelope follower and stereo gain multiply stages of the lookahead gate.
`timescale 1ns / 1ps
module lpg_gain (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  lpg_pkg::gain_ctrl_t                    ctrl,
  input  lpg_pkg::cfg_t                          cfg,
  input  logic [lpg_pkg::PROB_W-1:0]             prob,
  input  logic signed [lpg_pkg::SAMPLE_BITS-1:0] dl,
  input  logic signed [lpg_pkg::SAMPLE_BITS-1:0] dr,
  output logic [lpg_pkg::GAIN_W-1:0]             env,
  output logic signed [lpg_pkg::SAMPLE_BITS-1:0] ol,
  output logic signed [lpg_pkg::SAMPLE_BITS-1:0] orr
);
  import lpg_pkg::*;

  localparam int M1_W  = COEF_W + GAIN_W;
  localparam int ACC_W = M1_W + 1;
  localparam int PR_W  = SAMPLE_BITS + GAIN_W + 1;

  logic [GAIN_W-1:0]     env_r, env_nxt;
  logic [M1_W-1:0]       m1_r;
  logic [GAIN_W-1:0]     tgt_r, ncoef_r;
  logic signed [PR_W-1:0] pl_r, pr_r;

  logic [GAIN_W-1:0] target;
  logic [COEF_W-1:0] coef;
  logic [ACC_W-1:0]  acc;
  logic [GAIN_W:0]   acc_hi;

  always_comb begin
    target  = (prob < cfg.threshold) ? UNITY : cfg.floor_gain;
    coef    = (target < env_r) ? cfg.attack_coef : cfg.release_coef;
    acc     = ACC_W'(m1_r) + ACC_W'(ncoef_r * tgt_r);
    acc_hi  = (GAIN_W + 1)'(acc >> 16);
    env_nxt = (acc_hi > (GAIN_W + 1)'(UNITY)) ? UNITY : acc_hi[GAIN_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      env_r <= UNITY;
    end else if (ctrl.env_update) begin
      env_r <= env_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.env_pick) begin
      m1_r    <= M1_W'(coef * env_r);
      tgt_r   <= target;
      ncoef_r <= UNITY - GAIN_W'(coef);
    end
    if (ctrl.scale) begin
      pl_r <= PR_W'(dl) * $signed({1'b0, env_r});
      pr_r <= PR_W'(dr) * $signed({1'b0, env_r});
    end
  end

  assign env = env_r;
  assign ol  = SAMPLE_BITS'(pl_r >>> 16);
  assign orr = SAMPLE_BITS'(pr_r >>> 16);

endmodule

// ===== test/testbench.sv =====
// Testbench for the lookahead probability gate: directed table, random words, bit-true scoreboard.
`timescale 1ns / 1ps
module testbench;
  import lpg_pkg::*;

  typedef struct {
    int        set_id;
    in_word_t  word;
    bit        typed;
    out_word_t want;
  } plan_row_t;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_word_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_word_t out_data;
  logic      cfg_we;
  logic [IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_data;

  cfg_t gate_cfg = '{
    delay_length: 16'd36000,
    prob_offset:  -17'sd10112,
    threshold:    16'd32768,
    floor_gain:   17'd0,
    attack_coef:  16'd65264,
    release_coef: 16'd65509
  };

  bit signed [SAMPLE_BITS-1:0] left_store  [DELAY_DEPTH];
  bit signed [SAMPLE_BITS-1:0] right_store [DELAY_DEPTH];
  bit [15:0]             wr_pos;
  bit [PROB_W-1:0]       ring [PROB_DEPTH];
  bit [11:0]             counter;
  bit [GAIN_W-1:0]       envelope = UNITY;
  bit [SAMPLE_BITS-1:0]  peak_in;
  bit [SAMPLE_BITS-1:0]  peak_out;

  out_word_t gated_due [$];
  plan_row_t plan [$];
  cfg_t      gate_sets [4];

  int  fail_count;
  int  words_checked;
  int  prob_writes;
  int  samples_sent;
  int  cfg_loads;
  bit  quiet;
  bit  squeeze_go;
  bit  squeeze_done;

  lookahead_probability_gate u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  task automatic report_mismatch(input string msg);
    if (fail_count < 100) begin
      $display("MISMATCH at %0t: %s", $realtime, msg);
    end
    fail_count++;
  endtask

  function automatic in_word_t mk_word(input logic cmd, input logic [11:0] idx,
                                       input logic [15:0] val, input logic [23:0] l,
                                       input logic [23:0] r, input logic bs);
    in_word_t w;
    w.command     = cmd;
    w.prob_index  = idx;
    w.prob_value  = val;
    w.left_in     = l;
    w.right_in    = r;
    w.block_start = bs;
    return w;
  endfunction

  function automatic void add_row(input int set_id, input in_word_t w, input bit typed,
                                  input out_word_t want);
    plan_row_t row;
    row.set_id = set_id;
    row.word   = w;
    row.typed  = typed;
    row.want   = want;
    plan.push_back(row);
  endfunction

  task automatic gate_word(input in_word_t w, output bit made, output out_word_t res);
    bit [15:0]            rd;
    bit [11:0]            rp;
    bit signed [23:0]     dl;
    bit signed [23:0]     dr;
    bit [PROB_W-1:0]      prob;
    bit [GAIN_W-1:0]      target;
    bit [COEF_W-1:0]      coef;
    longint unsigned      acc;
    longint               pl;
    longint               pr;
    longint               g;
    longint               mag;
    made = 1'b0;
    res  = '0;
    if (w.command == CMD_PROB_WRITE) begin
      ring[w.prob_index] = w.prob_value;
      prob_writes++;
    end else begin
      samples_sent++;
      if (w.block_start) begin
        peak_in  = '0;
        peak_out = '0;
      end
      rd = wr_pos - gate_cfg.delay_length;
      dl = left_store[rd];
      dr = right_store[rd];
      left_store[wr_pos]  = w.left_in;
      right_store[wr_pos] = w.right_in;
      wr_pos++;
      rp = counter + gate_cfg.prob_offset[11:0];
      prob = ring[rp];
      target = (prob < gate_cfg.threshold) ? UNITY : gate_cfg.floor_gain;
      coef = (target < envelope) ? gate_cfg.attack_coef : gate_cfg.release_coef;
      acc = 64'(coef) * 64'(envelope) + (64'(UNITY) - 64'(coef)) * 64'(target);
      envelope = ((acc >> 16) > 64'(UNITY)) ? UNITY : GAIN_W'(acc >> 16);
      g  = envelope;
      pl = dl;
      pl = (pl * g) >>> 16;
      pr = dr;
      pr = (pr * g) >>> 16;
      mag = dl;
      if (mag < 0) mag = -mag;
      if (mag > longint'(peak_in)) peak_in = mag[23:0];
      mag = pl;
      if (mag < 0) mag = -mag;
      if (mag > longint'(peak_out)) peak_out = mag[23:0];
      counter++;
      res.left_out    = pl[23:0];
      res.right_out   = pr[23:0];
      res.gain        = envelope;
      res.probability = prob;
      res.in_peak     = peak_in;
      res.out_peak    = peak_out;
      made = 1'b1;
    end
  endtask

  task automatic send_word(input in_word_t w, input bit typed, input out_word_t want);
    bit        made;
    out_word_t res;
    @(negedge clk);
    while (!quiet && $urandom_range(0, 99) < 20) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    gate_word(w, made, res);
    if (made) gated_due.push_back(typed ? want : res);
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_DELAY_LENGTH: gate_cfg.delay_length = val[15:0];
      CFG_PROB_OFFSET:  gate_cfg.prob_offset  = val;
      CFG_THRESHOLD:    gate_cfg.threshold    = val[15:0];
      CFG_FLOOR_GAIN:   gate_cfg.floor_gain   = (val > UNITY) ? UNITY : val;
      CFG_ATTACK_COEF:  gate_cfg.attack_coef  = val[15:0];
      CFG_RELEASE_COEF: gate_cfg.release_coef = val[15:0];
      default: ;
    endcase
  endtask

  task automatic load_cfg(input cfg_t c);
    write_reg(CFG_DELAY_LENGTH, CFG_W'(c.delay_length));
    write_reg(CFG_PROB_OFFSET,  CFG_W'(c.prob_offset));
    write_reg(CFG_THRESHOLD,    CFG_W'(c.threshold));
    write_reg(CFG_FLOOR_GAIN,   CFG_W'(c.floor_gain));
    write_reg(CFG_ATTACK_COEF,  CFG_W'(c.attack_coef));
    write_reg(CFG_RELEASE_COEF, CFG_W'(c.release_coef));
    cfg_loads++;
  endtask

  task automatic drain(input int settle);
    int spins;
    spins = 0;
    @(negedge clk);
    in_valid <= 1'b0;
    while (gated_due.size() != 0 && spins < 200000) begin
      @(posedge clk);
      spins++;
    end
    repeat (settle) @(posedge clk);
  endtask

  always @(posedge clk) begin
    out_word_t want;
    if (rst_n && out_valid && out_ready) begin
      if (gated_due.size() == 0) begin
        report_mismatch($sformatf("result word with nothing pending: %h", out_data));
      end else begin
        want = gated_due.pop_front();
        words_checked++;
        if (out_data.left_out !== want.left_out)
          report_mismatch($sformatf("left_out got %0d want %0d",
                                    out_data.left_out, want.left_out));
        if (out_data.right_out !== want.right_out)
          report_mismatch($sformatf("right_out got %0d want %0d",
                                    out_data.right_out, want.right_out));
        if (out_data.gain !== want.gain)
          report_mismatch($sformatf("gain got %0d want %0d", out_data.gain, want.gain));
        if (out_data.probability !== want.probability)
          report_mismatch($sformatf("probability got %0d want %0d",
                                    out_data.probability, want.probability));
        if (out_data.in_peak !== want.in_peak)
          report_mismatch($sformatf("in_peak got %0d want %0d",
                                    out_data.in_peak, want.in_peak));
        if (out_data.out_peak !== want.out_peak)
          report_mismatch($sformatf("out_peak got %0d want %0d",
                                    out_data.out_peak, want.out_peak));
      end
    end
  end

  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (squeeze_go && !squeeze_done) begin
        squeeze_done = 1'b1;
        repeat (400) begin
          out_ready <= 1'b0;
          @(negedge clk);
        end
      end
      out_ready <= (quiet || $urandom_range(0, 99) >= 20);
    end
  end

  initial begin
    #(5_000_000);
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    int        cur_set;
    int        seg;
    int        n;
    in_word_t  w;
    cfg_t      c;
    out_word_t unity_zero;
    out_word_t none;

    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    none      = '0;
    unity_zero = '{left_out: '0, right_out: '0, gain: UNITY, probability: '0,
                   in_peak: '0, out_peak: '0};

    gate_sets[0] = gate_cfg;
    gate_sets[1] = '{delay_length: 16'd1, prob_offset: 17'sd0, threshold: 16'h8000,
                     floor_gain: 17'h04000, attack_coef: 16'hF000, release_coef: 16'h1000};
    gate_sets[2] = '{delay_length: 16'd0, prob_offset: -17'sd65536, threshold: 16'h0000,
                     floor_gain: 17'h1FFFF, attack_coef: 16'h0000, release_coef: 16'hFFFF};
    gate_sets[3] = '{delay_length: 16'hFFFF, prob_offset: 17'sd65535, threshold: 16'hFFFF,
                     floor_gain: UNITY, attack_coef: 16'hFFFF, release_coef: 16'h0000};

    add_row(0, mk_word(CMD_SAMPLE, 12'h000, 16'h0000, 24'h000000, 24'h000000, 1'b0),
            1'b1, unity_zero);
    add_row(0, mk_word(CMD_SAMPLE, 12'hFFF, 16'hFFFF, 24'h7FFFFF, 24'h800000, 1'b1),
            1'b1, unity_zero);
    add_row(1, mk_word(CMD_PROB_WRITE, 12'h002, 16'hFFFF, 24'h000000, 24'hFFFFFF, 1'b0),
            1'b0, none);
    add_row(1, mk_word(CMD_PROB_WRITE, 12'h003, 16'h8000, 24'h000000, 24'h000000, 1'b1),
            1'b0, none);
    add_row(1, mk_word(CMD_PROB_WRITE, 12'h004, 16'h7FFF, 24'h000000, 24'h000000, 1'b0),
            1'b0, none);
    add_row(1, mk_word(CMD_PROB_WRITE, 12'hFFF, 16'h0000, 24'h000000, 24'h000000, 1'b0),
            1'b0, none);
    add_row(1, mk_word(CMD_SAMPLE, 12'h000, 16'h0000, 24'h7FFFFF, 24'h800000, 1'b0),
            1'b0, none);
    add_row(1, mk_word(CMD_SAMPLE, 12'h000, 16'h0000, 24'h800000, 24'h7FFFFF, 1'b0),
            1'b0, none);
    add_row(1, mk_word(CMD_SAMPLE, 12'h000, 16'h0000, 24'h000000, 24'h000000, 1'b1),
            1'b0, none);
    add_row(1, mk_word(CMD_SAMPLE, 12'h000, 16'h0000, 24'hFFFFFF, 24'h000001, 1'b0),
            1'b0, none);
    add_row(1, mk_word(CMD_SAMPLE, 12'h000, 16'h0000, 24'h123456, 24'hEDCBAA, 1'b0),
            1'b0, none);
    add_row(2, mk_word(CMD_PROB_WRITE, 12'h007, 16'h1234, 24'h000000, 24'h000000, 1'b0),
            1'b0, none);
    add_row(2, mk_word(CMD_SAMPLE, 12'h000, 16'h0000, 24'h400000, 24'hC00000, 1'b1),
            1'b0, none);
    add_row(2, mk_word(CMD_SAMPLE, 12'h000, 16'h0000, 24'h7FFFFF, 24'h800000, 1'b0),
            1'b0, none);
    add_row(2, mk_word(CMD_SAMPLE, 12'h000, 16'h0000, 24'h000000, 24'h000000, 1'b0),
            1'b0, none);
    add_row(3, mk_word(CMD_PROB_WRITE, 12'h009, 16'hFFFF, 24'h000000, 24'h000000, 1'b0),
            1'b0, none);
    add_row(3, mk_word(CMD_SAMPLE, 12'h000, 16'h0000, 24'h800000, 24'h7FFFFF, 1'b1),
            1'b0, none);
    add_row(3, mk_word(CMD_SAMPLE, 12'h000, 16'h0000, 24'h555555, 24'hAAAAAA, 1'b0),
            1'b0, none);
    add_row(3, mk_word(CMD_SAMPLE, 12'h000, 16'h0000, 24'hAAAAAA, 24'h555555, 1'b0),
            1'b0, none);

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    cur_set = 0;
    foreach (plan[i]) begin
      if (plan[i].set_id != cur_set) begin
        drain(16);
        cur_set = plan[i].set_id;
        load_cfg(gate_sets[cur_set]);
      end
      send_word(plan[i].word, plan[i].typed, plan[i].want);
    end

    for (seg = 0; seg < 4; seg++) begin
      drain(16);
      c.delay_length = ($urandom_range(0, 5) == 0) ? 16'($urandom)
                                                   : 16'($urandom_range(0, 40));
      c.prob_offset  = $urandom_range(0, 1) ? 17'($urandom)
                                            : 17'($urandom_range(0, 32)) - 17'd16;
      c.threshold    = 16'($urandom);
      c.floor_gain   = 17'($urandom_range(0, 131071));
      c.attack_coef  = $urandom_range(0, 1) ? 16'($urandom_range(60000, 65535))
                                            : 16'($urandom);
      c.release_coef = $urandom_range(0, 1) ? 16'($urandom_range(60000, 65535))
                                            : 16'($urandom);
      load_cfg(c);
      for (n = 0; n < 135; n++) begin
        if (seg == 1 && n == 30) squeeze_go = 1'b1;
        quiet = (seg == 2 && n >= 20 && n < 120);
        w.command     = ($urandom_range(0, 99) < 65) ? CMD_SAMPLE : CMD_PROB_WRITE;
        w.prob_index  = 12'($urandom);
        w.prob_value  = 16'($urandom);
        w.left_in     = 24'($urandom);
        w.right_in    = 24'($urandom);
        w.block_start = ($urandom_range(0, 19) == 0);
        if (w.command == CMD_PROB_WRITE && $urandom_range(0, 3) != 0)
          w.prob_index = counter + gate_cfg.prob_offset[11:0] + 12'($urandom_range(0, 12));
        if ($urandom_range(0, 3) == 0)
          w.prob_value = gate_cfg.threshold + 16'($urandom_range(0, 2)) - 16'd1;
        case ($urandom_range(0, 15))
          0: w.left_in  = 24'h7FFFFF;
          1: w.left_in  = 24'h800000;
          2: w.right_in = 24'h7FFFFF;
          3: w.right_in = 24'h800000;
          default: ;
        endcase
        send_word(w, 1'b0, none);
      end
      quiet = 1'b0;
    end

    drain(32);
    if (gated_due.size() != 0)
      report_mismatch($sformatf("%0d result words never arrived", gated_due.size()));

    $display("Covered %0d probability writes and %0d samples over %0d register loads.",
             prob_writes, samples_sent, cfg_loads);
    $display("Compared %0d result words, %0d mismatches.", words_checked, fail_count);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/lpg_pkg.sv
rtl/core/lpg_ram.sv
rtl/core/lpg_gain.sv
rtl/core/lookahead_probability_gate.sv
test/testbench.sv
